// ===== hw/rtl/bswc_pkg.sv =====
// Shared types, codes and constants of the backlight schedule and wake controller.
// No dependencies; every other file of the block refers to it by scoped names.
package bswc_pkg;

    localparam int unsigned SLOTS          = 6;
    localparam int unsigned SLOT_BITS      = 21;
    localparam int unsigned SLOTS_PER_WORD = 3;
    localparam int unsigned START_BITS     = 11;
    localparam int unsigned LEVEL_BITS     = 7;
    localparam int unsigned PERIOD_W       = 63;
    localparam int unsigned MAX_PERIODS_DEF = 6;
    localparam int unsigned GRACE_MS_DEF    = 500;

    localparam int unsigned S_DATA_W = 56;
    localparam int unsigned S_USER_W = 2;
    localparam int unsigned M_DATA_W = 24;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 63;
    localparam int unsigned TIMEOUT_MS_W = 26;

    localparam logic [1:0] OP_UPDATE  = 2'd0;
    localparam logic [1:0] OP_TOUCH   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [2:0] REG_SCHED_ENABLE   = 3'd0;
    localparam logic [2:0] REG_PERIOD_COUNT   = 3'd1;
    localparam logic [2:0] REG_WAKE_TIMEOUT_S = 3'd2;
    localparam logic [2:0] REG_TOUCH_LEVEL    = 3'd3;
    localparam logic [2:0] REG_MANUAL_LEVEL   = 3'd4;
    localparam logic [2:0] REG_PERIODS_LO     = 3'd5;
    localparam logic [2:0] REG_PERIODS_HI     = 3'd6;

    localparam logic [6:0] DIM_LIMIT      = 7'd5;
    localparam logic [6:0] UNSYNCED_LEVEL = 7'd50;
    localparam logic [6:0] RESET_LEVEL    = 7'd80;
    localparam logic [6:0] RESET_TOUCH    = 7'd100;
    localparam logic [7:0] NONE_APPLIED   = 8'd255;
    localparam logic [2:0] NO_PERIOD      = 3'd7;
    localparam logic [15:0] RESET_TIMEOUT_S = 16'd30;
    localparam logic [9:0]  MS_PER_S        = 10'd1000;

    typedef struct packed {
        logic                    enable;
        logic [2:0]              count;
        logic [TIMEOUT_MS_W-1:0] timeout_ms;
        logic [6:0]              touch_level;
        logic [6:0]              manual_level;
        logic [PERIOD_W-1:0]     periods_lo;
        logic [PERIOD_W-1:0]     periods_hi;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now_ms;
        logic        time_synced;
        logic [4:0]  hour_now;
        logic [5:0]  minute_now;
        logic [6:0]  actual_level;
    } item_t;

    typedef struct packed {
        logic       is_awake;
        logic [6:0] target_level;
        logic       block_buttons;
        logic       handled;
        logic [6:0] apply_level;
        logic       apply_valid;
    } res_t;

endpackage

// ===== hw/rtl/bswc_cfg_regs.sv =====
// Configuration register file with the wake timeout kept in milliseconds.
// Depends on bswc_pkg.
module bswc_cfg_regs #(
    parameter int unsigned MAX_PERIODS = bswc_pkg::MAX_PERIODS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [bswc_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [bswc_pkg::CFG_DATA_W-1:0]   wr_data,
    output bswc_pkg::cfg_t                    cfg
);

    localparam logic [2:0] MAX_CNT = 3'(MAX_PERIODS);

    bswc_pkg::cfg_t cfg_reg;
    bswc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                bswc_pkg::REG_SCHED_ENABLE:   cfg_next.enable = wr_data[0];
                bswc_pkg::REG_PERIOD_COUNT: begin
                    cfg_next.count = (wr_data[2:0] > MAX_CNT) ? MAX_CNT : wr_data[2:0];
                end
                bswc_pkg::REG_WAKE_TIMEOUT_S: begin
                    cfg_next.timeout_ms = bswc_pkg::TIMEOUT_MS_W'(wr_data[15:0])
                                        * bswc_pkg::TIMEOUT_MS_W'(bswc_pkg::MS_PER_S);
                end
                bswc_pkg::REG_TOUCH_LEVEL:    cfg_next.touch_level  = wr_data[6:0];
                bswc_pkg::REG_MANUAL_LEVEL:   cfg_next.manual_level = wr_data[6:0];
                bswc_pkg::REG_PERIODS_LO:     cfg_next.periods_lo   = wr_data;
                bswc_pkg::REG_PERIODS_HI:     cfg_next.periods_hi   = wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable       <= 1'b0;
            cfg_reg.count        <= 3'd0;
            cfg_reg.timeout_ms   <= bswc_pkg::TIMEOUT_MS_W'(bswc_pkg::RESET_TIMEOUT_S)
                                  * bswc_pkg::TIMEOUT_MS_W'(bswc_pkg::MS_PER_S);
            cfg_reg.touch_level  <= bswc_pkg::RESET_TOUCH;
            cfg_reg.manual_level <= bswc_pkg::RESET_LEVEL;
            cfg_reg.periods_lo   <= '0;
            cfg_reg.periods_hi   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/bswc_period_find.sv =====
// Active period search: last sorted slot whose start minute is not after now.
// Depends on bswc_pkg.
module bswc_period_find #(
    parameter int unsigned MAX_PERIODS = bswc_pkg::MAX_PERIODS_DEF
) (
    input  logic [4:0]                       hour_now,
    input  logic [5:0]                       minute_now,
    input  logic [2:0]                       count,
    input  logic [bswc_pkg::PERIOD_W-1:0]    periods_lo,
    input  logic [bswc_pkg::PERIOD_W-1:0]    periods_hi,
    output logic [2:0]                       period_idx,
    output logic [6:0]                       period_level
);

    localparam int unsigned SB = bswc_pkg::SLOT_BITS;

    logic [2*bswc_pkg::PERIOD_W-1:0] all_slots;
    logic [SB-1:0] slot [bswc_pkg::SLOTS];
    logic [bswc_pkg::START_BITS-1:0] cur_min;
    logic [2:0] act;
    logic       stop;

    assign all_slots = {periods_hi, periods_lo};

    always_comb begin
        for (int i = 0; i < bswc_pkg::SLOTS; i++) begin
            slot[i] = all_slots[i*SB +: SB];
        end
    end

    assign cur_min = bswc_pkg::START_BITS'(hour_now) * bswc_pkg::START_BITS'(60)
                   + bswc_pkg::START_BITS'(minute_now);

    always_comb begin
        act  = count - 3'd1;
        stop = 1'b0;
        for (int i = 0; i < MAX_PERIODS; i++) begin
            if (!stop && (3'(i) < count)) begin
                if (slot[i][bswc_pkg::START_BITS-1:0] <= cur_min) begin
                    act = 3'(i);
                end else begin
                    stop = 1'b1;
                end
            end
        end
    end

    assign period_idx   = act;
    assign period_level = (act < 3'(bswc_pkg::SLOTS))
                        ? slot[act][bswc_pkg::START_BITS +: bswc_pkg::LEVEL_BITS] : 7'd0;

endmodule

// ===== hw/rtl/bswc_engine.sv =====
// Controller state, per-event decision logic and the result register.
// Depends on bswc_pkg; takes the active period from bswc_period_find.
module bswc_engine #(
    parameter int unsigned GRACE_MS = bswc_pkg::GRACE_MS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fire,
    input  bswc_pkg::item_t item,
    input  bswc_pkg::cfg_t  cfg,
    input  logic [2:0]      period_idx,
    input  logic [6:0]      period_level,
    output bswc_pkg::res_t  res
);

    logic        awake_reg,  awake_next;
    logic [6:0]  sched_reg,  sched_next;
    logic [7:0]  last_reg,   last_next;
    logic [31:0] wake_reg,   wake_next;
    logic [31:0] grace_reg,  grace_next;
    logic [2:0]  active_reg, active_next;
    bswc_pkg::res_t res_reg, res_next;

    logic        n_nz;
    logic        timed_out;
    logic        dim;
    logic [31:0] elapsed;

    assign n_nz      = (cfg.count != 3'd0);
    assign elapsed   = item.now_ms - wake_reg;
    assign timed_out = (elapsed >= 32'(cfg.timeout_ms));
    assign dim       = (item.actual_level <= bswc_pkg::DIM_LIMIT);

    always_comb begin
        logic       aw;
        logic [7:0] la;
        logic [6:0] sl;
        logic [6:0] want;
        aw = awake_reg;
        la = last_reg;
        sl = sched_reg;
        want = '0;
        awake_next  = awake_reg;
        sched_next  = sched_reg;
        last_next   = last_reg;
        wake_next   = wake_reg;
        grace_next  = grace_reg;
        active_next = active_reg;
        res_next    = '0;

        unique case (item.op)
            bswc_pkg::OP_UPDATE: begin
                if (cfg.enable && n_nz) begin
                    if (!item.time_synced) begin
                        if (last_reg != 8'(bswc_pkg::UNSYNCED_LEVEL)) begin
                            res_next.apply_valid = 1'b1;
                            res_next.apply_level = bswc_pkg::UNSYNCED_LEVEL;
                            res_next.handled     = 1'b1;
                            last_next = 8'(bswc_pkg::UNSYNCED_LEVEL);
                        end
                    end else begin
                        if (awake_reg && timed_out) begin
                            aw = 1'b0;
                            la = bswc_pkg::NONE_APPLIED;
                        end
                        if (period_idx != active_reg) begin
                            active_next = period_idx;
                            sl = period_level;
                        end
                        want = aw ? cfg.touch_level : sl;
                        awake_next = aw;
                        sched_next = sl;
                        last_next  = la;
                        if (8'(want) != la) begin
                            res_next.apply_valid = 1'b1;
                            res_next.apply_level = want;
                            res_next.handled     = 1'b1;
                            last_next = 8'(want);
                        end
                    end
                end
            end
            bswc_pkg::OP_TOUCH: begin
                if (cfg.enable) begin
                    if (dim) begin
                        awake_next = 1'b1;
                        wake_next  = item.now_ms;
                        grace_next = item.now_ms + 32'(GRACE_MS);
                        last_next  = 8'(cfg.touch_level);
                        res_next.apply_valid = 1'b1;
                        res_next.apply_level = cfg.touch_level;
                        res_next.handled     = 1'b1;
                    end else if (awake_reg) begin
                        wake_next = item.now_ms;
                    end
                end
            end
            bswc_pkg::OP_RESTART: begin
                if (cfg.enable) begin
                    awake_next  = 1'b0;
                    active_next = bswc_pkg::NO_PERIOD;
                    last_next   = bswc_pkg::NONE_APPLIED;
                    if (item.time_synced && n_nz) begin
                        active_next = period_idx;
                        sched_next  = period_level;
                        last_next   = 8'(period_level);
                        res_next.apply_valid = 1'b1;
                        res_next.apply_level = period_level;
                    end else if (!item.time_synced) begin
                        last_next = 8'(bswc_pkg::UNSYNCED_LEVEL);
                        res_next.apply_valid = 1'b1;
                        res_next.apply_level = bswc_pkg::UNSYNCED_LEVEL;
                    end
                end
            end
            default: ;
        endcase

        if (!cfg.enable) begin
            res_next.target_level = cfg.manual_level;
        end else if (awake_next) begin
            res_next.target_level = cfg.touch_level;
        end else if (!item.time_synced) begin
            res_next.target_level = bswc_pkg::UNSYNCED_LEVEL;
        end else begin
            res_next.target_level = sched_next;
        end
        res_next.block_buttons = cfg.enable && ((item.now_ms < grace_next) || dim);
        res_next.is_awake      = awake_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awake_reg  <= 1'b0;
            sched_reg  <= bswc_pkg::RESET_LEVEL;
            last_reg   <= bswc_pkg::NONE_APPLIED;
            wake_reg   <= '0;
            grace_reg  <= '0;
            active_reg <= bswc_pkg::NO_PERIOD;
        end else if (fire) begin
            awake_reg  <= awake_next;
            sched_reg  <= sched_next;
            last_reg   <= last_next;
            wake_reg   <= wake_next;
            grace_reg  <= grace_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== hw/rtl/backlight_schedule_wake_controller_unit.sv =====
// Top level of the backlight schedule and wake controller: stream ports, input register.
// Depends on bswc_pkg, bswc_cfg_regs, bswc_period_find and bswc_engine.
//
// Usage:
//   s_ channel: one event per transaction (tuser = operation: update tick, touch,
//   restart). m_ channel: exactly one result transaction per event, in order.
//   cfg channel: register writes, always ready; write only while no event is in flight.
// Path: an accepted event is held in the input register and its result in the result
//   register, which drives m_ and holds while m_ is stalled.
// Throughput: one event per cycle while m_ is not stalled; the period search, timeout
//   check and level decision are all combinational between input and result register.
// Reset: aresetn low clears both stages, loads configuration defaults (scheduling
//   off, no periods, 30 s timeout, touch level 100, manual level 80) and the
//   controller state (scheduled level 80, nothing applied, no active period).
// Stall: while m_tready is low the result register holds; one more event may sit
//   in the input register, after which s_tready drops until m_ drains.
module backlight_schedule_wake_controller_unit #(
    parameter int unsigned MAX_PERIODS = bswc_pkg::MAX_PERIODS_DEF,
    parameter int unsigned GRACE_MS    = bswc_pkg::GRACE_MS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // now_ms[31:0], time_synced[32], hour_now[37:33], minute_now[43:38],
    // actual_level[50:44], zero fill[55:51]
    input  logic [bswc_pkg::S_DATA_W-1:0]      s_tdata,
    // operation[1:0]
    input  logic [bswc_pkg::S_USER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // apply_valid[0], apply_level[7:1], handled[8], block_buttons[9],
    // target_level[16:10], is_awake[17], zero fill[23:18]
    output logic [bswc_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bswc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bswc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic            in_valid_reg;
    bswc_pkg::item_t item_reg;
    logic            out_valid_reg;
    logic            advance;
    logic            fire;
    bswc_pkg::cfg_t  cfg;
    bswc_pkg::res_t  res;
    logic [2:0]      period_idx;
    logic [6:0]      period_level;

    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.op           <= s_tuser[1:0];
            item_reg.now_ms       <= s_tdata[31:0];
            item_reg.time_synced  <= s_tdata[32];
            item_reg.hour_now     <= s_tdata[37:33];
            item_reg.minute_now   <= s_tdata[43:38];
            item_reg.actual_level <= s_tdata[50:44];
        end
    end

    bswc_cfg_regs #(
        .MAX_PERIODS(MAX_PERIODS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_valid && cfg_ready),
        .wr_index(cfg_index),
        .wr_data (cfg_data),
        .cfg     (cfg)
    );

    bswc_period_find #(
        .MAX_PERIODS(MAX_PERIODS)
    ) u_find (
        .hour_now    (item_reg.hour_now),
        .minute_now  (item_reg.minute_now),
        .count       (cfg.count),
        .periods_lo  (cfg.periods_lo),
        .periods_hi  (cfg.periods_hi),
        .period_idx  (period_idx),
        .period_level(period_level)
    );

    bswc_engine #(
        .GRACE_MS(GRACE_MS)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .item        (item_reg),
        .cfg         (cfg),
        .period_idx  (period_idx),
        .period_level(period_level),
        .res         (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, res.is_awake, res.target_level, res.block_buttons,
                       res.handled, res.apply_level, res.apply_valid};

endmodule

// ===== hw/rtl/bswc_checker.sv =====
// Port-level checks of the backlight schedule and wake controller, bound to the top.
// Depends on bswc_pkg and backlight_schedule_wake_controller_unit.
module bswc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bswc_pkg::M_DATA_W-1:0]     m_tdata
);

    a_level_zero_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[7:1] == 7'd0))
        else $error("apply_level nonzero without apply_valid");

    a_handled_implies_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> m_tdata[0])
        else $error("handled set without a level issued");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

bind backlight_schedule_wake_controller_unit bswc_checker u_bswc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
